// ----- rtl/best_fit_arena_allocator_defines.svh -----
// Assertion macros used by the allocator control module.
`ifndef BEST_FIT_ARENA_ALLOCATOR_DEFINES_SVH
`define BEST_FIT_ARENA_ALLOCATOR_DEFINES_SVH

// Asserts that an antecedent implies a consequent in the same cycle.
`define BFA_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Asserts that an antecedent implies a consequent in the next cycle.
`define BFA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/bfa_pkg.sv -----
package bfa_pkg;

  localparam int FREE_ENTRIES_DEF = 32;
  localparam int ALLOC_ENTRIES_DEF = 32;
  localparam int GRANULE_BYTES_DEF = 256;

  localparam int START_W = 24;
  localparam int LEN_W = 25;
  localparam int REQ_W = 32;
  localparam int ADDR_W = 32;
  localparam int BYTES_W = 33;
  localparam int STATUS_W = 3;

  localparam logic [LEN_W-1:0] REGION_MAX = 25'd16777216;
  localparam logic [LEN_W-1:0] REGION_RESET = 25'd4096;

  localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOFIT = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ZERO = 3'd4;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  typedef struct packed {
    logic init;
    logic load;
    logic scan_alloc;
    logic scan_free;
    logic commit;
  } bfa_cmd_t;

  typedef struct packed {
    logic is_release;
    logic zero_req;
    logic scan_done;
    logic init_done;
  } bfa_stat_t;

endpackage

// ----- rtl/bfa_if.sv -----
interface bfa_in_if;
  logic valid;
  logic ready;
  logic command;
  logic [bfa_pkg::REQ_W-1:0] request_bytes;
  logic [bfa_pkg::ADDR_W-1:0] release_address;
  modport source (output valid, command, request_bytes, release_address, input ready);
  modport sink (input valid, command, request_bytes, release_address, output ready);
endinterface

interface bfa_out_if;
  logic valid;
  logic ready;
  logic [bfa_pkg::STATUS_W-1:0] status;
  logic [bfa_pkg::ADDR_W-1:0] address;
  logic [bfa_pkg::BYTES_W-1:0] granted_bytes;
  modport source (output valid, status, address, granted_bytes, input ready);
  modport sink (input valid, status, address, granted_bytes, output ready);
endinterface

interface bfa_cfg_if;
  logic valid;
  logic ready;
  logic [bfa_pkg::LEN_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ----- rtl/bfa_ctrl.sv -----
`include "best_fit_arena_allocator_defines.svh"

module bfa_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  bfa_pkg::bfa_stat_t  stat,
  output bfa_pkg::bfa_cmd_t   cmd
);

  typedef enum logic [5:0] {
    S_INIT  = 6'b000001,
    S_IDLE  = 6'b000010,
    S_ALLOC = 6'b000100,
    S_FREE  = 6'b001000,
    S_DONE  = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    cfg_ready = 1'b0;
    case (state)
      S_INIT: begin
        cmd.init = 1'b1;
        if (stat.init_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        cfg_ready = 1'b1;
        in_ready = !cfg_valid;
        if (cfg_valid) begin
          state_next = S_INIT;
        end else if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_ALLOC;
        end
      end
      S_ALLOC: begin
        cmd.scan_alloc = 1'b1;
        if (stat.zero_req) begin
          state_next = S_DONE;
        end else if (stat.scan_done) begin
          state_next = S_FREE;
        end
      end
      S_FREE: begin
        cmd.scan_free = 1'b1;
        if (stat.scan_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        cmd.commit = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  `BFA_ASSERT_IMP(a_in_idle, clk, rst, in_ready, state == S_IDLE)
  `BFA_ASSERT_IMP(a_excl, clk, rst, out_valid, !in_ready && !cfg_ready)
  `BFA_ASSERT_NEXT(a_load, clk, rst, in_valid && in_ready, state == S_ALLOC)
  `BFA_ASSERT_NEXT(a_commit, clk, rst, cmd.commit, out_valid)

endmodule

// ----- rtl/bfa_datapath.sv -----
module bfa_datapath #(
  parameter int FREE_ENTRIES = bfa_pkg::FREE_ENTRIES_DEF,
  parameter int ALLOC_ENTRIES = bfa_pkg::ALLOC_ENTRIES_DEF,
  parameter int GRANULE_BYTES = bfa_pkg::GRANULE_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  bfa_pkg::bfa_cmd_t                cmd,
  output bfa_pkg::bfa_stat_t               stat,
  input  logic                             cfg_we,
  input  logic [bfa_pkg::LEN_W-1:0]        cfg_data,
  input  logic                             in_command,
  input  logic [bfa_pkg::REQ_W-1:0]        in_request_bytes,
  input  logic [bfa_pkg::ADDR_W-1:0]       in_release_address,
  output logic [bfa_pkg::STATUS_W-1:0]     status,
  output logic [bfa_pkg::ADDR_W-1:0]       address,
  output logic [bfa_pkg::BYTES_W-1:0]      granted_bytes
);

  // The granule size must be a power of two, so scaling by it is a shift; this is not checked.
  localparam int SW = bfa_pkg::START_W;
  localparam int LW = bfa_pkg::LEN_W;
  localparam int ADDR_W_L = bfa_pkg::ADDR_W;
  localparam int FI_W = (FREE_ENTRIES > 1) ? $clog2(FREE_ENTRIES) : 1;
  localparam int AI_W = (ALLOC_ENTRIES > 1) ? $clog2(ALLOC_ENTRIES) : 1;
  localparam int CNT_W = ((FREE_ENTRIES > ALLOC_ENTRIES) ?
                          $clog2(FREE_ENTRIES + 1) : $clog2(ALLOC_ENTRIES + 1));
  localparam int GW = $clog2(GRANULE_BYTES);
  localparam int NEED_W = 34;
  localparam logic [NEED_W-1:0] GB = NEED_W'(GRANULE_BYTES);
  localparam logic [CNT_W-1:0] FREE_LAST = CNT_W'(FREE_ENTRIES - 1);
  localparam logic [CNT_W-1:0] ALLOC_LAST = CNT_W'(ALLOC_ENTRIES - 1);

  logic [LW-1:0] region;
  logic [SW-1:0] fstart [FREE_ENTRIES];
  logic [LW-1:0] flen [FREE_ENTRIES];
  logic [FREE_ENTRIES-1:0] fused;
  logic [SW-1:0] astart [ALLOC_ENTRIES];
  logic [LW-1:0] alen [ALLOC_ENTRIES];
  logic [ALLOC_ENTRIES-1:0] aused;

  logic is_rel;
  logic [NEED_W-1:0] need;
  logic [ADDR_W_L-1:0] raddr;
  logic [CNT_W-1:0] idx;
  logic a_found;
  logic [AI_W-1:0] a_idx;
  logic b_found, p_found, s_found, sp_found;
  logic [FI_W-1:0] b_idx, p_idx, s_idx, sp_idx;
  logic [LW-1:0] b_len;
  logic [SW-1:0] b_start;

  logic [FI_W-1:0] fi;
  logic [AI_W-1:0] ai;
  logic [NEED_W-1:0] need_calc;
  logic [NEED_W-1:0] a_byte;
  logic [NEED_W-1:0] f_end;
  logic [NEED_W-1:0] rel_s, rel_e;
  logic [LW-1:0] cfg_clamped;

  assign fi = idx[FI_W-1:0];
  assign ai = idx[AI_W-1:0];
  assign need_calc = (NEED_W'(in_request_bytes) + GB - NEED_W'(1)) >> GW;
  assign a_byte = (NEED_W'(astart[ai]) << GW) & NEED_W'(34'hFFFFFFFF);
  assign f_end = NEED_W'(fstart[fi]) + NEED_W'(flen[fi]);
  assign rel_s = NEED_W'(astart[a_idx]);
  assign rel_e = rel_s + NEED_W'(alen[a_idx]);

  always_comb begin
    if (cfg_data == '0) begin
      cfg_clamped = LW'(1);
    end else if (cfg_data > bfa_pkg::REGION_MAX) begin
      cfg_clamped = bfa_pkg::REGION_MAX;
    end else begin
      cfg_clamped = cfg_data;
    end
  end

  always_comb begin
    stat.is_release = is_rel;
    stat.zero_req = !is_rel && need == '0;
    stat.init_done = 1'b1;
    if (cmd.scan_alloc) begin
      stat.scan_done = (idx == ALLOC_LAST) ||
                       (is_rel ? (aused[ai] && a_byte == NEED_W'(raddr)) : !aused[ai]);
    end else begin
      stat.scan_done = (idx == FREE_LAST);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      region <= bfa_pkg::REGION_RESET;
    end else if (cfg_we) begin
      region <= cfg_clamped;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.init) begin
      fused <= FREE_ENTRIES'(1);
      aused <= '0;
      fstart[0] <= '0;
      flen[0] <= region;
    end else if (cmd.load) begin
      is_rel <= in_command == bfa_pkg::CMD_RELEASE;
      need <= need_calc;
      raddr <= in_release_address;
      idx <= '0;
      a_found <= 1'b0;
      b_found <= 1'b0;
      p_found <= 1'b0;
      s_found <= 1'b0;
      sp_found <= 1'b0;
    end else if (cmd.scan_alloc) begin
      if (is_rel ? (aused[ai] && a_byte == NEED_W'(raddr)) : !aused[ai]) begin
        a_found <= 1'b1;
        a_idx <= ai;
      end
      idx <= stat.scan_done ? '0 : idx + CNT_W'(1);
    end else if (cmd.scan_free) begin
      idx <= idx + CNT_W'(1);
      if (!is_rel) begin
        if (fused[fi] && NEED_W'(flen[fi]) >= need &&
            (!b_found || flen[fi] < b_len || (flen[fi] == b_len && fstart[fi] < b_start))) begin
          b_found <= 1'b1;
          b_idx <= fi;
          b_len <= flen[fi];
          b_start <= fstart[fi];
        end
      end else if (!fused[fi]) begin
        if (!sp_found) begin
          sp_found <= 1'b1;
          sp_idx <= fi;
        end
      end else if (f_end == rel_s && !p_found) begin
        p_found <= 1'b1;
        p_idx <= fi;
      end else if (NEED_W'(fstart[fi]) == rel_e && !s_found) begin
        s_found <= 1'b1;
        s_idx <= fi;
      end
    end else if (cmd.commit) begin
      if (!is_rel) begin
        if (need == '0) begin
          status <= bfa_pkg::ST_ZERO;
          address <= '0;
          granted_bytes <= '0;
        end else if (!a_found) begin
          status <= bfa_pkg::ST_FULL;
          address <= '0;
          granted_bytes <= '0;
        end else if (!b_found) begin
          status <= bfa_pkg::ST_NOFIT;
          address <= '0;
          granted_bytes <= '0;
        end else begin
          status <= bfa_pkg::ST_OK;
          aused[a_idx] <= 1'b1;
          astart[a_idx] <= b_start;
          alen[a_idx] <= need[LW-1:0];
          if (NEED_W'(b_len) > need) begin
            fstart[b_idx] <= b_start + need[SW-1:0];
            flen[b_idx] <= b_len - need[LW-1:0];
          end else begin
            fused[b_idx] <= 1'b0;
          end
          address <= ADDR_W_L'(NEED_W'(b_start) << GW);
          granted_bytes <= bfa_pkg::BYTES_W'(need << GW);
        end
      end else begin
        if (!a_found) begin
          status <= bfa_pkg::ST_UNKNOWN;
          address <= '0;
          granted_bytes <= '0;
        end else if (!p_found && !s_found && !sp_found) begin
          status <= bfa_pkg::ST_FULL;
          address <= '0;
          granted_bytes <= '0;
        end else begin
          status <= bfa_pkg::ST_OK;
          aused[a_idx] <= 1'b0;
          if (p_found) begin
            if (s_found) begin
              flen[p_idx] <= flen[p_idx] + alen[a_idx] + flen[s_idx];
              fused[s_idx] <= 1'b0;
            end else begin
              flen[p_idx] <= flen[p_idx] + alen[a_idx];
            end
          end else if (s_found) begin
            fstart[s_idx] <= astart[a_idx];
            flen[s_idx] <= flen[s_idx] + alen[a_idx];
          end else begin
            fstart[sp_idx] <= astart[a_idx];
            flen[sp_idx] <= alen[a_idx];
            fused[sp_idx] <= 1'b1;
          end
          address <= ADDR_W_L'(rel_s << GW);
          granted_bytes <= bfa_pkg::BYTES_W'(NEED_W'(alen[a_idx]) << GW);
        end
      end
    end
  end

endmodule

// ----- rtl/best_fit_arena_allocator.sv -----
// A request is loaded, scans the allocation table and then the free table, then is committed.
// A zero-byte request skips the free table scan and goes straight to the commit.
// A new transaction is accepted only after the previous result has been taken.
// Reset (rst, synchronous): region size 4096 granules, one free chunk, no allocations.
// A configuration write reinitializes both tables.
module best_fit_arena_allocator #(
  parameter int FREE_ENTRIES = bfa_pkg::FREE_ENTRIES_DEF,
  parameter int ALLOC_ENTRIES = bfa_pkg::ALLOC_ENTRIES_DEF,
  parameter int GRANULE_BYTES = bfa_pkg::GRANULE_BYTES_DEF
) (
  input logic clk,
  input logic rst,
  bfa_in_if.sink in,
  bfa_out_if.source out,
  bfa_cfg_if.sink cfg
);

  bfa_pkg::bfa_cmd_t cmd;
  bfa_pkg::bfa_stat_t stat;

  bfa_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in.valid), .in_ready(in.ready),
    .out_valid(out.valid), .out_ready(out.ready),
    .cfg_valid(cfg.valid), .cfg_ready(cfg.ready),
    .stat(stat), .cmd(cmd)
  );

  bfa_datapath #(
    .FREE_ENTRIES(FREE_ENTRIES), .ALLOC_ENTRIES(ALLOC_ENTRIES),
    .GRANULE_BYTES(GRANULE_BYTES)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .cfg_we(cfg.valid && cfg.ready), .cfg_data(cfg.data),
    .in_command(in.command), .in_request_bytes(in.request_bytes),
    .in_release_address(in.release_address),
    .status(out.status), .address(out.address), .granted_bytes(out.granted_bytes)
  );

endmodule

// ----- tb/tb.sv -----
module tb;

  localparam int STATUS_W = bfa_pkg::STATUS_W;
  localparam int ADDR_W = bfa_pkg::ADDR_W;
  localparam int BYTES_W = bfa_pkg::BYTES_W;
  localparam int LEN_W = bfa_pkg::LEN_W;
  localparam int START_W = bfa_pkg::START_W;
  localparam int REQ_W = bfa_pkg::REQ_W;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0] address;
    logic [BYTES_W-1:0] granted_bytes;
  } arena_result_t;

  localparam int NFREE = bfa_pkg::FREE_ENTRIES_DEF;
  localparam int NALLOC = bfa_pkg::ALLOC_ENTRIES_DEF;
  localparam int GRAN = bfa_pkg::GRANULE_BYTES_DEF;
  localparam int DRAIN_CYCLES = 80;
  localparam int STALL_LIMIT = 5000;

  logic clk;
  logic rst;

  bfa_in_if in_if();
  bfa_out_if out_if();
  bfa_cfg_if cfg_if();

  best_fit_arena_allocator DUT (
    .clk(clk),
    .rst(rst),
    .in(in_if.sink),
    .out(out_if.source),
    .cfg(cfg_if.sink)
  );

  logic [LEN_W-1:0] region_size;
  logic [START_W-1:0] chunk_start[NFREE];
  logic [LEN_W-1:0] chunk_len[NFREE];
  bit chunk_live[NFREE];
  logic [START_W-1:0] grant_start[NALLOC];
  logic [LEN_W-1:0] grant_len[NALLOC];
  bit grant_live[NALLOC];

  arena_result_t pending_results[$];
  int errors;
  int items_sent;
  int results_seen;
  int stall_cycles;
  int hold_left;
  bit calm;
  int status_hits[5];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic clear_tables();
    for (int i = 0; i < NFREE; i++) begin
      chunk_start[i] = '0;
      chunk_len[i] = '0;
      chunk_live[i] = 1'b0;
    end
    for (int i = 0; i < NALLOC; i++) begin
      grant_start[i] = '0;
      grant_len[i] = '0;
      grant_live[i] = 1'b0;
    end
    chunk_live[0] = 1'b1;
    chunk_len[0] = region_size;
  endtask

  function automatic arena_result_t do_alloc(logic [REQ_W-1:0] req);
    arena_result_t r;
    longint unsigned need;
    int slot;
    int best;
    r = '0;
    slot = -1;
    best = -1;
    if (req == 0) begin
      r.status = bfa_pkg::ST_ZERO;
      return r;
    end
    need = (longint'(req) + GRAN - 1) / GRAN;
    for (int i = NALLOC - 1; i >= 0; i--) if (!grant_live[i]) slot = i;
    if (slot < 0) begin
      r.status = bfa_pkg::ST_FULL;
      return r;
    end
    for (int i = 0; i < NFREE; i++) begin
      if (!chunk_live[i] || longint'(chunk_len[i]) < need) continue;
      if (best < 0 || chunk_len[i] < chunk_len[best] ||
          (chunk_len[i] == chunk_len[best] && chunk_start[i] < chunk_start[best]))
        best = i;
    end
    if (best < 0) begin
      r.status = bfa_pkg::ST_NOFIT;
      return r;
    end
    grant_start[slot] = chunk_start[best];
    grant_len[slot] = LEN_W'(need);
    grant_live[slot] = 1'b1;
    if (longint'(chunk_len[best]) > need) begin
      chunk_start[best] = START_W'(chunk_start[best] + need);
      chunk_len[best] = LEN_W'(chunk_len[best] - need);
    end else begin
      chunk_live[best] = 1'b0;
      chunk_start[best] = '0;
      chunk_len[best] = '0;
    end
    r.status = bfa_pkg::ST_OK;
    r.address = ADDR_W'(longint'(grant_start[slot]) * GRAN);
    r.granted_bytes = BYTES_W'(need * GRAN);
    return r;
  endfunction

  function automatic arena_result_t do_release(logic [ADDR_W-1:0] addr);
    arena_result_t r;
    int a, pred, succ, spare;
    longint unsigned s, e;
    r = '0;
    a = -1;
    pred = -1;
    succ = -1;
    spare = -1;
    for (int i = 0; i < NALLOC; i++)
      if (a < 0 && grant_live[i] && ((longint'(grant_start[i]) * GRAN) & 32'hFFFFFFFF) == addr)
        a = i;
    if (a < 0) begin
      r.status = bfa_pkg::ST_UNKNOWN;
      return r;
    end
    s = grant_start[a];
    e = s + grant_len[a];
    for (int i = 0; i < NFREE; i++) begin
      if (!chunk_live[i]) begin
        if (spare < 0) spare = i;
        continue;
      end
      if (longint'(chunk_start[i]) + chunk_len[i] == s && pred < 0) pred = i;
      else if (longint'(chunk_start[i]) == e && succ < 0) succ = i;
    end
    if (pred >= 0) begin
      chunk_len[pred] = chunk_len[pred] + grant_len[a];
      if (succ >= 0) begin
        chunk_len[pred] = chunk_len[pred] + chunk_len[succ];
        chunk_live[succ] = 1'b0;
        chunk_start[succ] = '0;
        chunk_len[succ] = '0;
      end
    end else if (succ >= 0) begin
      chunk_start[succ] = START_W'(s);
      chunk_len[succ] = chunk_len[succ] + grant_len[a];
    end else if (spare >= 0) begin
      chunk_start[spare] = START_W'(s);
      chunk_len[spare] = grant_len[a];
      chunk_live[spare] = 1'b1;
    end else begin
      r.status = bfa_pkg::ST_FULL;
      return r;
    end
    r.status = bfa_pkg::ST_OK;
    r.address = ADDR_W'(s * GRAN);
    r.granted_bytes = BYTES_W'(longint'(grant_len[a]) * GRAN);
    grant_live[a] = 1'b0;
    grant_start[a] = '0;
    grant_len[a] = '0;
    return r;
  endfunction

  // Drives one transaction; valid stays high afterwards until the next call or the end.
  task automatic send(logic cmd, logic [REQ_W-1:0] req, logic [ADDR_W-1:0] addr);
    @(negedge clk);
    if (!calm && $urandom_range(99) < 22) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.command = cmd;
    in_if.request_bytes = req;
    in_if.release_address = addr;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    if (cmd == bfa_pkg::CMD_ALLOC)
      pending_results.insert(pending_results.size(), do_alloc(req));
    else
      pending_results.insert(pending_results.size(), do_release(addr));
    items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_region(logic [LEN_W-1:0] value);
    wait_drained();
    @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.data = value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    if (value == 0) region_size = LEN_W'(1);
    else if (value > bfa_pkg::REGION_MAX) region_size = bfa_pkg::REGION_MAX;
    else region_size = value;
    clear_tables();
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  function automatic logic [ADDR_W-1:0] pick_live_address();
    int idx[$];
    for (int i = 0; i < NALLOC; i++) if (grant_live[i]) idx.insert(idx.size(), i);
    if (idx.size() == 0) return ADDR_W'($urandom_range(255) * GRAN);
    return ADDR_W'(grant_start[idx[$urandom_range(idx.size() - 1)]] * GRAN);
  endfunction

  task automatic random_item(int max_granules);
    int roll;
    roll = $urandom_range(99);
    if (roll < 50)
      send(bfa_pkg::CMD_ALLOC, $urandom_range(max_granules * GRAN), $urandom);
    else if (roll < 58)
      send(bfa_pkg::CMD_ALLOC, $urandom, $urandom);
    else if (roll < 92)
      send(bfa_pkg::CMD_RELEASE, $urandom, pick_live_address());
    else if (roll < 96)
      send(bfa_pkg::CMD_RELEASE, $urandom, ADDR_W'($urandom_range(4095) * GRAN));
    else
      send(bfa_pkg::CMD_RELEASE, $urandom, $urandom);
  endtask

  task automatic test_directed();
    send(bfa_pkg::CMD_ALLOC, 32'd0, 32'hFFFFFFFF);
    send(bfa_pkg::CMD_ALLOC, 32'd1, 32'd0);
    send(bfa_pkg::CMD_ALLOC, 32'd256, 32'd0);
    send(bfa_pkg::CMD_ALLOC, 32'd257, 32'd0);
    send(bfa_pkg::CMD_ALLOC, 32'hFFFFFFFF, 32'd0);
    send(bfa_pkg::CMD_RELEASE, 32'hFFFFFFFF, 32'h12345);
    send(bfa_pkg::CMD_RELEASE, 32'd0, 32'd256);
    send(bfa_pkg::CMD_RELEASE, 32'd0, 32'd0);
    send(bfa_pkg::CMD_RELEASE, 32'd0, 32'd512);
    send(bfa_pkg::CMD_RELEASE, 32'd0, 32'd256);
    write_region(25'h1FFFFFF);
    send(bfa_pkg::CMD_ALLOC, 32'hFFFFFFFF, 32'd0);
    send(bfa_pkg::CMD_ALLOC, 32'd1, 32'd0);
    send(bfa_pkg::CMD_RELEASE, 32'd0, 32'd0);
    send(bfa_pkg::CMD_ALLOC, 32'h80000000, 32'd0);
    send(bfa_pkg::CMD_ALLOC, 32'h80000000, 32'd0);
    send(bfa_pkg::CMD_RELEASE, 32'd0, 32'h80000000);
    write_region(25'd0);
    send(bfa_pkg::CMD_ALLOC, 32'd200, 32'd0);
    send(bfa_pkg::CMD_ALLOC, 32'd1, 32'd0);
    send(bfa_pkg::CMD_RELEASE, 32'd0, 32'd0);
  endtask

  task automatic test_table_full();
    write_region(25'd64);
    for (int i = 0; i < NALLOC + 1; i++) send(bfa_pkg::CMD_ALLOC, 32'd256, 32'd0);
    for (int i = 0; i < NALLOC; i += 2) send(bfa_pkg::CMD_RELEASE, 32'd0, ADDR_W'(i * GRAN));
    for (int i = 1; i < NALLOC; i += 2) send(bfa_pkg::CMD_RELEASE, 32'd0, ADDR_W'(i * GRAN));
  endtask

  task automatic test_random(logic [LEN_W-1:0] region, int count, int max_granules);
    write_region(region);
    for (int i = 0; i < count; i++) random_item(max_granules);
  endtask

  task automatic test_backpressure();
    write_region(25'd4096);
    calm = 1'b1;
    hold_left = 400;
    for (int i = 0; i < 20; i++) random_item(16);
    calm = 1'b0;
    wait_drained();
    for (int i = 0; i < 10; i++) random_item(16);
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    in_if.valid = 1'b0;
    in_if.command = bfa_pkg::CMD_ALLOC;
    in_if.request_bytes = '0;
    in_if.release_address = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    errors = 0;
    items_sent = 0;
    results_seen = 0;
    hold_left = 0;
    calm = 1'b0;
    region_size = bfa_pkg::REGION_RESET;
    clear_tables();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_table_full();
    test_random(25'd48, 260, 6);
    calm = 1'b1;
    test_random(25'd4096, 260, 300);
    calm = 1'b0;
    test_random(25'd200, 260, 20);
    test_backpressure();
    test_random(25'd16777216, 280, 4096);
    wait_drained();

    $display("Covered %0d transactions and %0d results over several region sizes.",
             items_sent, results_seen);
    $display("Status counts: ok %0d, no fit %0d, full %0d, unknown %0d, zero %0d.",
             status_hits[0], status_hits[1], status_hits[2], status_hits[3], status_hits[4]);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_if.ready = 1'b0;
        hold_left--;
      end else begin
        out_if.ready = !rst && (calm || $urandom_range(99) >= 22);
      end
    end
  end

  always @(posedge clk) begin
    arena_result_t exp_r;
    if (!rst && out_if.valid && out_if.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status %0d address %h bytes %h", $time,
                 out_if.status, out_if.address, out_if.granted_bytes);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (exp_r.status <= bfa_pkg::ST_ZERO) status_hits[exp_r.status]++;
        if (out_if.status !== exp_r.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status, out_if.status);
          errors++;
        end
        if (out_if.address !== exp_r.address) begin
          $display("%0t: address expected %h actual %h", $time, exp_r.address, out_if.address);
          errors++;
        end
        if (out_if.granted_bytes !== exp_r.granted_bytes) begin
          $display("%0t: granted_bytes expected %h actual %h", $time,
                   exp_r.granted_bytes, out_if.granted_bytes);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready) || hold_left > 0 ||
        (pending_results.size() == 0 && !in_if.valid && !cfg_if.valid)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

endmodule

// ----- best_fit_arena_allocator.f -----
+incdir+rtl
rtl/bfa_pkg.sv
rtl/bfa_if.sv
rtl/bfa_ctrl.sv
rtl/bfa_datapath.sv
rtl/best_fit_arena_allocator.sv
tb/tb.sv
